// ===== design/lrtf_pkg.sv =====
// Package for the learning route table forwarder.
// Holds table sizes, item kinds, register indexes, FSM states and the entry type.
// No dependencies.
package lrtf_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int PORT_COUNT    = 8;

  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int CFG_IDX_W = 3;

  localparam logic [7:0] PORT_RANGE_MASK = 8'((1 << PORT_COUNT) - 1);

  typedef enum logic [2:0] {
    KIND_FORWARD = 3'd0,
    KIND_SET     = 3'd1,
    KIND_REMOVE  = 3'd2,
    KIND_LOOKUP  = 3'd3,
    KIND_ONLINE  = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACHED  = 3'd0,
    REG_TIMEOUT   = 3'd1,
    REG_LOCAL     = 3'd2,
    REG_BROADCAST = 3'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [7:0]  addr;
    logic [2:0]  port;
    logic [31:0] last_seen;
  } entry_t;

endpackage

// ===== design/learning_route_table_forwarder_unit.sv =====
// Top level of the learning route table forwarder.
// Table memory, scan sequencer and result logic; depends on lrtf_pkg.
//
// Sequence: from the accepting edge the scan states read every table entry
// through the registered table read and compare it, then the finish state
// writes back and registers the result and the done strobe. The single read
// port visits each table entry once per item, and a new item is accepted only
// in idle, so the block takes no new item until the last one is done.
// Reset: synchronous rst clears all entry valid bits at once and loads register
// defaults; no clearing pass. Results cannot be stalled by the receiver.
module learning_route_table_forwarder_unit (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    kind,
  input  logic [7:0]                    node_address,
  input  logic [7:0]                    destination_address,
  input  logic [2:0]                    port,
  input  logic [31:0]                   now_ms,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lrtf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  // result; done is high for a single cycle per transaction
  output logic                          done,
  output logic                          ok,
  output logic [7:0]                    port_mask,
  output logic [2:0]                    route_port,
  output logic                          route_found,
  output logic                          node_online,
  output logic                          local_delivery
);
  import lrtf_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers. Ready only while idle, so writes only land then.
  // ---------------------------------------------------------------------------
  logic [7:0]  attached_ports;
  logic [31:0] online_timeout;
  logic [7:0]  local_address;
  logic [7:0]  broadcast_address;

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      attached_ports    <= 8'd0;
      online_timeout    <= 32'd1000;
      local_address     <= 8'd0;
      broadcast_address <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_ATTACHED:  attached_ports    <= cfg_data[7:0];
        REG_TIMEOUT:   online_timeout    <= cfg_data;
        REG_LOCAL:     local_address     <= cfg_data[7:0];
        REG_BROADCAST: broadcast_address <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: idle -> scan every entry -> finish (write back + result)
  // ---------------------------------------------------------------------------
  state_t state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             accept;
  logic             scan_last;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  // last compare happens when the counter has passed every read address
  assign scan_last = (cnt == CNT_W'(TABLE_ENTRIES));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_SCAN;
      ST_SCAN:   if (scan_last) state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Latched command
  logic [2:0]  cmd_kind;
  logic [7:0]  cmd_addr;
  logic [7:0]  cmd_dest;
  logic [2:0]  cmd_port;
  logic [31:0] cmd_now;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_kind <= kind;
      cmd_addr <= node_address;
      cmd_dest <= destination_address;
      cmd_port <= port;
      cmd_now  <= now_ms;
    end
  end

  // ---------------------------------------------------------------------------
  // Table memory: one read port, one write port, registered read data.
  // Valid bits live in flops so reset clears the table at once.
  // ---------------------------------------------------------------------------
  entry_t               table_mem [TABLE_ENTRIES];
  entry_t               rd_data;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_idx;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  entry_t               wr_data;
  logic [TABLE_ENTRIES-1:0] valid_bits;

  assign rd_en  = (state == ST_SCAN) && (cnt < CNT_W'(TABLE_ENTRIES));
  assign rd_idx = cnt[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= table_mem[rd_idx];
    end
    if (wr_en) begin
      table_mem[wr_idx] <= wr_data;
    end
  end

  // Scan counter and compare-stage pipeline
  logic             cmp_en;
  logic [IDX_W-1:0] cmp_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= rd_en;
      if (accept) begin
        cnt <= '0;
      end else if (state == ST_SCAN && !scan_last) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cmp_idx <= rd_idx;
    end
  end

  // Scan results: source match, destination match, lowest free slot.
  logic             src_hit;
  logic [IDX_W-1:0] src_idx;
  logic [2:0]       src_port;
  logic [31:0]      src_time;
  logic             dst_hit;
  logic [2:0]       dst_port;
  logic             free_hit;
  logic [IDX_W-1:0] free_idx;
  logic             cmp_valid;

  assign cmp_valid = valid_bits[cmp_idx];

  always_ff @(posedge clk) begin
    if (accept) begin
      src_hit  <= 1'b0;
      dst_hit  <= 1'b0;
      free_hit <= 1'b0;
    end else if (cmp_en) begin
      if (cmp_valid && rd_data.addr == cmd_addr && !src_hit) begin
        src_hit  <= 1'b1;
        src_idx  <= cmp_idx;
        src_port <= rd_data.port;
        src_time <= rd_data.last_seen;
      end
      if (cmp_valid && rd_data.addr == cmd_dest && !dst_hit) begin
        dst_hit  <= 1'b1;
        dst_port <= rd_data.port;
      end
      if (!cmp_valid && !free_hit) begin
        free_hit <= 1'b1;
        free_idx <= cmp_idx;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Finish: decide write-back and result
  // ---------------------------------------------------------------------------
  logic        p_usable;
  logic        r_usable;
  logic        learned;
  logic        set_valid;
  logic        clr_valid;
  logic        fin;
  logic        r_ok, r_found, r_online, r_local;
  logic [7:0]  r_mask;
  logic [2:0]  r_port;
  logic [2:0]  uc_port;
  logic        uc_found;
  logic [31:0] age;

  assign fin      = (state == ST_FINISH);
  assign p_usable = ({1'b0, cmd_port} < 4'(PORT_COUNT)) && attached_ports[cmd_port];
  assign learned  = src_hit || (p_usable && free_hit);
  // a destination equal to the source sees the entry just learned
  assign uc_found = (cmd_dest == cmd_addr) ? learned  : dst_hit;
  assign uc_port  = (cmd_dest == cmd_addr) ? cmd_port : dst_port;
  assign r_usable = ({1'b0, uc_port} < 4'(PORT_COUNT)) && attached_ports[uc_port];
  assign age      = cmd_now - src_time;

  always_comb begin
    wr_en     = 1'b0;
    wr_idx    = src_idx;
    wr_data   = '{addr: cmd_addr, port: cmd_port, last_seen: cmd_now};
    set_valid = 1'b0;
    clr_valid = 1'b0;
    r_ok      = 1'b0;
    r_mask    = 8'd0;
    r_port    = 3'd0;
    r_found   = 1'b0;
    r_online  = 1'b0;
    r_local   = 1'b0;
    case (kind_t'(cmd_kind))
      KIND_FORWARD: begin
        if (src_hit) begin
          wr_en = fin;
        end else if (p_usable && free_hit) begin
          wr_en     = fin;
          wr_idx    = free_idx;
          set_valid = fin;
        end
        if (cmd_dest == local_address) begin
          r_ok    = 1'b1;
          r_local = 1'b1;
        end else if (cmd_dest == broadcast_address) begin
          r_mask = attached_ports & PORT_RANGE_MASK & ~(8'd1 << cmd_port);
          r_ok   = |r_mask;
        end else if (uc_found) begin
          r_found = 1'b1;
          r_port  = uc_port;
          if (uc_port != cmd_port && r_usable) begin
            r_ok   = 1'b1;
            r_mask = 8'd1 << uc_port;
          end
        end
      end
      KIND_SET: begin
        if (p_usable && src_hit) begin
          wr_en             = fin;
          wr_data.last_seen = src_time;
          r_ok              = 1'b1;
        end else if (p_usable && free_hit) begin
          wr_en             = fin;
          wr_idx            = free_idx;
          wr_data.last_seen = 32'd0;
          set_valid         = fin;
          r_ok              = 1'b1;
        end
      end
      KIND_REMOVE: begin
        clr_valid = fin && src_hit;
        r_ok      = src_hit;
      end
      KIND_LOOKUP: begin
        r_found = src_hit;
        r_port  = src_hit ? src_port : 3'd0;
        r_ok    = src_hit;
      end
      KIND_ONLINE: begin
        r_found  = src_hit;
        r_port   = src_hit ? src_port : 3'd0;
        r_online = src_hit && (age <= online_timeout);
        r_ok     = r_online;
      end
      default: ;
    endcase
  end

  // Valid bits: removed entries only drop the bit, their stale data is read but never matched.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else begin
      if (set_valid) valid_bits[wr_idx]  <= 1'b1;
      if (clr_valid) valid_bits[src_idx] <= 1'b0;
    end
  end

  // Result strobe, shown for exactly one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      ok             <= r_ok;
      port_mask      <= r_mask;
      route_port     <= r_port;
      route_found    <= r_found;
      node_online    <= r_online;
      local_delivery <= r_local;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_FINISH)
    else $error("result strobe without a finish cycle");

  a_write_only_finish: assert property (@(posedge clk) disable iff (rst)
    (wr_en || clr_valid) |-> state == ST_FINISH)
    else $error("table written outside the finish cycle");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_SCAN && cnt == '0)
    else $error("accepted transaction did not start a scan");

  a_local_ok: assert property (@(posedge clk) disable iff (rst)
    (done && local_delivery) |-> ok && port_mask == 8'd0)
    else $error("local delivery with bad status");

endmodule
